[src/mwcs_pkg.sv]
// Shared constants, types and codes for the maximum-weight cycle search block.
package mwcs_pkg;

  localparam int MAX_NODES = 10;
  localparam int NODE_W    = 4;
  localparam int WT_W      = 12;
  localparam int TOT_W     = 17;
  localparam int ADDR_W    = $clog2(MAX_NODES * MAX_NODES);
  localparam int ENTRIES   = MAX_NODES * MAX_NODES;
  localparam int Q_DEPTH   = 2;

  localparam logic signed [TOT_W-1:0] TOTAL_MIN = {1'b1, {(TOT_W-1){1'b0}}};

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  // One classified request as it travels from front to back.
  typedef struct packed {
    op_t                     op;
    logic [ADDR_W-1:0]       addr;
    logic signed [WT_W-1:0]  weight;
    logic [NODE_W-1:0]       count;
  } cmd_t;

endpackage

[src/mwcs_if.sv]
// Request and result channel interfaces.
interface mwcs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic [3:0]                           from_node;
  logic [3:0]                           to_node;
  logic signed [mwcs_pkg::WT_W-1:0]     weight;
  logic [3:0]                           node_count;
  modport source (output valid, opcode, from_node, to_node, weight, node_count, input ready);
  modport sink   (input valid, opcode, from_node, to_node, weight, node_count, output ready);
endinterface

interface mwcs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mwcs_pkg::TOT_W-1:0]    best_total;
  modport source (output valid, best_total, input ready);
  modport sink   (input valid, best_total, output ready);
endinterface

[src/mwcs_front.sv]
// Front end: accepts requests, classifies them and queues them for the engine.
module mwcs_front (
  input  logic            clk,
  input  logic            rst_n,
  mwcs_in_if.sink         in_ch,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output mwcs_pkg::cmd_t  cmd
);

  mwcs_pkg::cmd_t q_r [mwcs_pkg::Q_DEPTH];
  logic           wptr_r, wptr_nxt;
  logic           rptr_r, rptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           acc, keep, push, pop;
  mwcs_pkg::cmd_t cls;

  assign in_ch.ready = (cnt_r != 2'(mwcs_pkg::Q_DEPTH));
  assign acc         = in_ch.valid && in_ch.ready;

  // Classify: clamp the count, drop writes that fall outside the table.
  always_comb begin
    cls.op     = mwcs_pkg::op_t'(in_ch.opcode);
    cls.addr   = mwcs_pkg::ADDR_W'(in_ch.from_node) * mwcs_pkg::ADDR_W'(mwcs_pkg::MAX_NODES)
               + mwcs_pkg::ADDR_W'(in_ch.to_node);
    cls.weight = in_ch.weight;
    cls.count  = (in_ch.node_count > mwcs_pkg::NODE_W'(mwcs_pkg::MAX_NODES))
               ? mwcs_pkg::NODE_W'(mwcs_pkg::MAX_NODES) : in_ch.node_count;
    keep = (cls.op == mwcs_pkg::OP_SEARCH)
        || (in_ch.from_node < mwcs_pkg::NODE_W'(mwcs_pkg::MAX_NODES)
            && in_ch.to_node < mwcs_pkg::NODE_W'(mwcs_pkg::MAX_NODES));
  end

  assign push      = acc && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(mwcs_pkg::Q_DEPTH)) else $error("queue overfilled");
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("queue count lost a push");
  a_cnt_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 2'd1) else $error("queue count lost a pop");

endmodule

[src/mwcs_back.sv]
// Back end: weight table, ordering enumerator, cycle summing and result register.
module mwcs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  mwcs_pkg::cmd_t  cmd,
  mwcs_out_if.source      out_ch
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SUM   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  typedef logic [mwcs_pkg::NODE_W-1:0] node_t;

  state_t                            state_r, state_nxt;
  node_t                             order_r [mwcs_pkg::MAX_NODES];
  node_t                             order_nxt [mwcs_pkg::MAX_NODES];
  node_t                             perm [mwcs_pkg::MAX_NODES];
  node_t                             swp [mwcs_pkg::MAX_NODES];
  node_t                             count_r, count_nxt;
  node_t                             k_r, k_nxt;
  logic signed [mwcs_pkg::TOT_W-1:0] acc_r, acc_nxt, best_r, best_nxt, total, pair;
  logic signed [mwcs_pkg::TOT_W-1:0] out_r, out_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic                              pend_r;
  logic signed [mwcs_pkg::WT_W-1:0]  mem [mwcs_pkg::ENTRIES];
  logic [mwcs_pkg::ENTRIES-1:0]      vld_r;
  logic signed [mwcs_pkg::WT_W-1:0]  rd0_r, rd1_r;
  logic                              v0_r, v1_r;
  logic [mwcs_pkg::ADDR_W-1:0]       addr0, addr1;
  node_t                             na, nb, prev, pi, pj, src;
  logic                              found, wr_en;

  // Read addresses for pair (order[k], order[k-1]) and its mirror entry.
  always_comb begin
    prev  = (k_r == '0) ? count_r - 1'b1 : k_r - 1'b1;
    na    = order_r[k_r];
    nb    = order_r[prev];
    addr0 = mwcs_pkg::ADDR_W'(na) * mwcs_pkg::ADDR_W'(mwcs_pkg::MAX_NODES)
          + mwcs_pkg::ADDR_W'(nb);
    addr1 = mwcs_pkg::ADDR_W'(nb) * mwcs_pkg::ADDR_W'(mwcs_pkg::MAX_NODES)
          + mwcs_pkg::ADDR_W'(na);
    pair  = (v0_r ? mwcs_pkg::TOT_W'(rd0_r) : '0) + (v1_r ? mwcs_pkg::TOT_W'(rd1_r) : '0);
    total = acc_r + pair;
  end

  // Next lexicographic ordering of places 1..count-1; node 0 stays first.
  always_comb begin
    found = 1'b0;
    pi    = '0;
    pj    = '0;
    for (int k = 1; k < mwcs_pkg::MAX_NODES - 1; k++) begin
      if (node_t'(k + 1) < count_r && order_r[k] < order_r[k + 1]) begin
        found = 1'b1;
        pi    = node_t'(k);
      end
    end
    for (int m = 1; m < mwcs_pkg::MAX_NODES; m++) begin
      if (node_t'(m) < count_r && node_t'(m) > pi && order_r[m] > order_r[pi]) begin
        pj = node_t'(m);
      end
    end
    swp     = order_r;
    swp[pi] = order_r[pj];
    swp[pj] = order_r[pi];
    src     = '0;
    for (int k = 0; k < mwcs_pkg::MAX_NODES; k++) begin
      src = count_r + pi - node_t'(k);
      perm[k] = (node_t'(k) > pi && node_t'(k) < count_r) ? swp[src] : swp[k];
    end
  end

  assign cmd_ready = (state_r == ST_IDLE);
  assign wr_en     = cmd_valid && cmd_ready && (cmd.op == mwcs_pkg::OP_WRITE);

  always_comb begin
    state_nxt     = state_r;
    order_nxt     = order_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    best_nxt      = best_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && cmd.op == mwcs_pkg::OP_SEARCH) begin
          count_nxt = cmd.count;
          k_nxt     = '0;
          acc_nxt   = '0;
          for (int i = 0; i < mwcs_pkg::MAX_NODES; i++) begin
            order_nxt[i] = node_t'(i);
          end
          if (cmd.count == '0) begin
            best_nxt  = '0;
            state_nxt = ST_DONE;
          end else begin
            best_nxt  = mwcs_pkg::TOTAL_MIN;
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (pend_r) begin
          acc_nxt = total;
        end
        k_nxt = k_r + 1'b1;
        if (k_r == count_r - 1'b1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Totals stay within 17 bits for any count up to the table size.
        if (total > best_r) begin
          best_nxt = total;
        end
        k_nxt   = '0;
        acc_nxt = '0;
        if (found) begin
          order_nxt = perm;
          state_nxt = ST_SUM;
        end else begin
          for (int i = 0; i < mwcs_pkg::MAX_NODES; i++) begin
            order_nxt[i] = node_t'(i);
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = best_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      acc_r       <= '0;
      best_r      <= mwcs_pkg::TOTAL_MIN;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      vld_r       <= '0;
      for (int i = 0; i < mwcs_pkg::MAX_NODES; i++) begin
        order_r[i] <= node_t'(i);
      end
    end else begin
      state_r     <= state_nxt;
      order_r     <= order_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      acc_r       <= acc_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= (state_r == ST_SUM);
      if (wr_en) begin
        vld_r[cmd.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    rd0_r <= mem[addr0];
    rd1_r <= mem[addr1];
    v0_r  <= vld_r[addr0];
    v1_r  <= vld_r[addr1];
    if (wr_en) begin
      mem[cmd.addr] <= cmd.weight;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.best_total = out_r;

  a_wr_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> vld_r[$past(cmd.addr)]) else $error("written entry not marked valid");
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> (k_r < count_r)) else $error("pair index past node count");
  a_first_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) |-> (order_r[0] == '0)) else $error("node 0 left first place");
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE)) else $error("result without search");

endmodule

[src/max_weight_cycle_search.sv]
// Top level of the maximum-weight cycle search block.
// Usage:
//   in_ch carries requests. opcode 0 writes weight[from_node][to_node]; a write
//   outside the table is taken and dropped. opcode 1 searches over node_count
//   nodes (clamped to the table size) and yields one result on out_ch.
//   out_ch carries best_total, the largest closed-cycle total where each
//   adjacent pair adds both directed weights.
// Timing:
//   A write is taken only while the engine is idle. A search of n nodes
//   visits (n-1)! orderings, reading one table read pair per cycle in ST_SUM
//   and then comparing and stepping the ordering in ST_DRAIN; n of 0 returns 0.
//   The engine handles one request at a time; a two-entry queue lets in_ch
//   keep accepting while it works, until the queue fills.
// Reset:
//   rst_n marks every weight table entry unwritten so that it reads as zero,
//   empties the queue and drops any pending result.
// Stall:
//   The result register holds best_total until out_ch.ready; the engine
//   then waits for that register before it can deliver the next result.
module max_weight_cycle_search (
  input  logic       clk,
  input  logic       rst_n,
  mwcs_in_if.sink    in_ch,
  mwcs_out_if.source out_ch
);

  logic           cmd_valid;
  logic           cmd_ready;
  mwcs_pkg::cmd_t cmd;

  mwcs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  mwcs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_ch    (out_ch)
  );

endmodule
